>>> hw/rtl/obbpd_pkg.sv
// Shared constants and types for the oriented box pair penetration depth block.
package obbpd_pkg;

  localparam int CENTER_W  = 60;
  localparam int AXIS_W    = 48;
  localparam int EXTENT_W  = 60;
  localparam int IN_DATA_W = 528;

  localparam int A_CENTER_LSB = 0;
  localparam int A_AXIS_X_LSB = 60;
  localparam int A_AXIS_Y_LSB = 108;
  localparam int A_AXIS_Z_LSB = 156;
  localparam int A_EXTENT_LSB = 204;
  localparam int B_CENTER_LSB = 264;
  localparam int B_AXIS_X_LSB = 324;
  localparam int B_AXIS_Y_LSB = 372;
  localparam int B_AXIS_Z_LSB = 420;
  localparam int B_EXTENT_LSB = 468;

  localparam int EPS_W      = 8;
  localparam logic [EPS_W-1:0] EPS_RESET = 8'd2;

  localparam int DEPTH_W     = 27;
  localparam int OUT_DATA_W  = 32;
  localparam int DEPTH_MAX   = 67108863;
  localparam int DEPTH_MIN   = -67108864;

  localparam int N_AXES = 15;

  // Control that rides along the cell chain with each pair.
  typedef struct packed {
    logic vld;
    logic sep;
    logic have;
  } obbpd_ctl_t;

endpackage

>>> hw/rtl/obbpd_prep.sv
// Front end: unpacks a box pair and forms rotation terms and center projections.
module obbpd_prep import obbpd_pkg::*; #(
  parameter int P = 20,
  parameter int A = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  logic [IN_DATA_W-1:0] data_i,
  input  logic [EPS_W-1:0]     eps_i,
  output logic                 vld_o,
  output logic [P-1:0]         ea_o [3],
  output logic [P-1:0]         eb_o [3],
  output logic [A+3:0]         ar_o [3][3],
  output logic signed [A+3:0]  r_o  [3][3],
  output logic signed [P+A+2:0] p_o [3],
  output logic signed [P+A+2:0] q_o [3]
);

  localparam int F    = A - 2;
  localparam int RW   = A + 4;
  localparam int PW   = P + A + 3;
  localparam int RSW  = 2 * A + 2;
  localparam int DPW  = P + 1 + A;

  logic [63:0] ac_w, bc_w, ae_w, be_w;
  logic [63:0] aax_w [3];
  logic [63:0] bax_w [3];
  logic signed [P:0]   d_w  [3];
  logic signed [A-1:0] ax_w [3][3];
  logic signed [A-1:0] bx_w [3][3];

  logic                v1_r;
  logic [P-1:0]        ea1_r [3];
  logic [P-1:0]        eb1_r [3];
  logic signed [2*A-1:0] rp_r [3][3][3];
  logic signed [DPW-1:0] pp_r [3][3];
  logic signed [DPW-1:0] qp_r [3][3];

  always_comb begin
    ac_w   = 64'(data_i[A_CENTER_LSB +: CENTER_W]);
    bc_w   = 64'(data_i[B_CENTER_LSB +: CENTER_W]);
    ae_w   = 64'(data_i[A_EXTENT_LSB +: EXTENT_W]);
    be_w   = 64'(data_i[B_EXTENT_LSB +: EXTENT_W]);
    aax_w[0] = 64'(data_i[A_AXIS_X_LSB +: AXIS_W]);
    aax_w[1] = 64'(data_i[A_AXIS_Y_LSB +: AXIS_W]);
    aax_w[2] = 64'(data_i[A_AXIS_Z_LSB +: AXIS_W]);
    bax_w[0] = 64'(data_i[B_AXIS_X_LSB +: AXIS_W]);
    bax_w[1] = 64'(data_i[B_AXIS_Y_LSB +: AXIS_W]);
    bax_w[2] = 64'(data_i[B_AXIS_Z_LSB +: AXIS_W]);
    for (int k = 0; k < 3; k++) begin
      d_w[k] = $signed({bc_w[k*P+P-1], bc_w[k*P +: P]})
             - $signed({ac_w[k*P+P-1], ac_w[k*P +: P]});
      for (int i = 0; i < 3; i++) begin
        ax_w[i][k] = $signed(aax_w[i][k*A +: A]);
        bx_w[i][k] = $signed(bax_w[i][k*A +: A]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ea1_r[k] <= ae_w[k*P +: P];
        eb1_r[k] <= be_w[k*P +: P];
      end
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          pp_r[i][k] <= d_w[k] * ax_w[i][k];
          qp_r[i][k] <= d_w[k] * bx_w[i][k];
          for (int j = 0; j < 3; j++) begin
            rp_r[i][j][k] <= ax_w[i][k] * bx_w[j][k];
          end
        end
      end
    end
  end

  logic signed [RSW-1:0] rs_w  [3][3];
  logic signed [RW-1:0]  r_w   [3][3];
  logic [RW-1:0]         ar_w  [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        // Round to F fraction bits: add half an LSB, then floor.
        rs_w[i][j] = RSW'(rp_r[i][j][0]) + RSW'(rp_r[i][j][1]) + RSW'(rp_r[i][j][2])
                   + (RSW'(1) <<< (F - 1));
        r_w[i][j]  = RW'(rs_w[i][j] >>> F);
        ar_w[i][j] = (r_w[i][j] < 0 ? RW'(-r_w[i][j]) : RW'(r_w[i][j])) + RW'(eps_i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ea_o[i] <= ea1_r[i];
        eb_o[i] <= eb1_r[i];
        p_o[i]  <= PW'(pp_r[i][0]) + PW'(pp_r[i][1]) + PW'(pp_r[i][2]);
        q_o[i]  <= PW'(qp_r[i][0]) + PW'(qp_r[i][1]) + PW'(qp_r[i][2]);
        for (int j = 0; j < 3; j++) begin
          r_o[i][j]  <= r_w[i][j];
          ar_o[i][j] <= ar_w[i][j];
        end
      end
    end
  end

endmodule

>>> hw/rtl/obbpd_cell.sv
// One cell of the axis chain: tests one candidate axis and updates the running result.
module obbpd_cell import obbpd_pkg::*; #(
  parameter int P = 20,
  parameter int A = 16,
  parameter int K = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  obbpd_ctl_t            ctl_i,
  input  logic signed [P+2*A+8:0] best_i,
  input  logic [P-1:0]          ea_i [3],
  input  logic [P-1:0]          eb_i [3],
  input  logic [A+3:0]          ar_i [3][3],
  input  logic signed [A+3:0]   r_i  [3][3],
  input  logic signed [P+A+2:0] p_i  [3],
  input  logic signed [P+A+2:0] q_i  [3],
  output obbpd_ctl_t            ctl_o,
  output logic signed [P+2*A+8:0] best_o,
  output logic [P-1:0]          ea_o [3],
  output logic [P-1:0]          eb_o [3],
  output logic [A+3:0]          ar_o [3][3],
  output logic signed [A+3:0]   r_o  [3][3],
  output logic signed [P+A+2:0] p_o  [3],
  output logic signed [P+A+2:0] q_o  [3]
);

  localparam int F    = A - 2;
  localparam int RW   = A + 4;
  localparam int PW   = P + A + 3;
  localparam int MW   = P + RW;
  localparam int SW   = MW + 2;
  localparam int CW   = PW + RW;
  localparam int OV_W = P + 2 * A + 9;
  localparam int CI   = (K >= 6) ? (K - 6) / 3 : 0;
  localparam int CJ   = (K >= 6) ? (K - 6) % 3 : 0;
  localparam int I1   = (CI + 1) % 3;
  localparam int I2   = (CI + 2) % 3;
  localparam int J1   = (CJ + 1) % 3;
  localparam int J2   = (CJ + 2) % 3;
  localparam logic [RW-1:0]        UP_U = RW'(1) << F;
  localparam logic signed [RW-1:0] UP_S = RW'(1) << F;

  logic [P-1:0]         e_w  [4];
  logic [RW-1:0]        a_w  [4];
  logic signed [PW-1:0] cp_w [2];
  logic signed [RW-1:0] cr_w [2];

  generate
    if (K < 3) begin : g_face_a
      always_comb begin
        for (int j = 0; j < 3; j++) begin
          e_w[j] = eb_i[j];
          a_w[j] = ar_i[K][j];
        end
        e_w[3]  = ea_i[K];
        a_w[3]  = UP_U;
        cp_w[0] = p_i[K];
        cr_w[0] = UP_S;
        cp_w[1] = '0;
        cr_w[1] = '0;
      end
    end else if (K < 6) begin : g_face_b
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          e_w[i] = ea_i[i];
          a_w[i] = ar_i[i][K-3];
        end
        e_w[3]  = eb_i[K-3];
        a_w[3]  = UP_U;
        cp_w[0] = q_i[K-3];
        cr_w[0] = UP_S;
        cp_w[1] = '0;
        cr_w[1] = '0;
      end
    end else begin : g_cross
      always_comb begin
        e_w[0]  = ea_i[I1];
        a_w[0]  = ar_i[I2][CJ];
        e_w[1]  = ea_i[I2];
        a_w[1]  = ar_i[I1][CJ];
        e_w[2]  = eb_i[J1];
        a_w[2]  = ar_i[CI][J2];
        e_w[3]  = eb_i[J2];
        a_w[3]  = ar_i[CI][J1];
        cp_w[0] = p_i[I2];
        cr_w[0] = r_i[I1][CJ];
        cp_w[1] = p_i[I1];
        cr_w[1] = r_i[I2][CJ];
      end
    end
  endgenerate

  // First stage: radius and center products.
  obbpd_ctl_t           ctl_a_r;
  obbpd_ctl_t           ctl_nxt;
  logic signed [OV_W-1:0] best_a_r;
  logic [MW-1:0]        m_r [4];
  logic signed [CW-1:0] c_r [2];
  logic [P-1:0]         ea_a_r [3];
  logic [P-1:0]         eb_a_r [3];
  logic [RW-1:0]        ar_a_r [3][3];
  logic signed [RW-1:0] r_a_r  [3][3];
  logic signed [PW-1:0] p_a_r  [3];
  logic signed [PW-1:0] q_a_r  [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_o   <= '0;
    end else if (en) begin
      ctl_a_r <= ctl_i;
      ctl_o   <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      best_a_r <= best_i;
      for (int n = 0; n < 4; n++) m_r[n] <= MW'(e_w[n]) * MW'(a_w[n]);
      for (int n = 0; n < 2; n++) c_r[n] <= CW'(cp_w[n]) * CW'(cr_w[n]);
      for (int i = 0; i < 3; i++) begin
        ea_a_r[i] <= ea_i[i];
        eb_a_r[i] <= eb_i[i];
        p_a_r[i]  <= p_i[i];
        q_a_r[i]  <= q_i[i];
        for (int j = 0; j < 3; j++) begin
          ar_a_r[i][j] <= ar_i[i][j];
          r_a_r[i][j]  <= r_i[i][j];
        end
      end
    end
  end

  // Second stage: overlap on this axis and the running min or first separation.
  logic [SW-1:0]          s_w;
  logic signed [CW:0]     c_w;
  logic signed [OV_W-1:0] ov_w;
  logic signed [OV_W-1:0] best_nxt;

  always_comb begin
    s_w  = SW'(m_r[0]) + SW'(m_r[1]) + SW'(m_r[2]) + SW'(m_r[3]);
    c_w  = (CW+1)'(c_r[0]) - (CW+1)'(c_r[1]);
    ov_w = $signed(OV_W'(s_w) << F)
         - (c_w < 0 ? OV_W'(-c_w) : OV_W'(c_w));
    ctl_nxt  = ctl_a_r;
    best_nxt = best_a_r;
    if (!ctl_a_r.sep) begin
      if (ov_w < 0) begin
        ctl_nxt.sep = 1'b1;
        best_nxt    = ov_w;
      end else if (!ctl_a_r.have || ov_w < best_a_r) begin
        ctl_nxt.have = 1'b1;
        best_nxt     = ov_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      best_o <= best_nxt;
      for (int i = 0; i < 3; i++) begin
        ea_o[i] <= ea_a_r[i];
        eb_o[i] <= eb_a_r[i];
        p_o[i]  <= p_a_r[i];
        q_o[i]  <= q_a_r[i];
        for (int j = 0; j < 3; j++) begin
          ar_o[i][j] <= ar_a_r[i][j];
          r_o[i][j]  <= r_a_r[i][j];
        end
      end
    end
  end

endmodule

>>> hw/rtl/obb_pair_penetration_depth.sv
// Top level: oriented box pair separating axis test with overlap flag and depth.
// An input transfer reaches the output register through two front-end stages,
// then two stages in each of the 15 axis cells, then the output register itself.
// Throughput is one box pair per cycle; the chain stalls only when the output
// register and its skid stage are both full.
// Synchronous active-low reset clears all valid bits and sets abs_epsilon to 2.
module obb_pair_penetration_depth import obbpd_pkg::*; #(
  parameter int POS_BITS  = 20,
  parameter int AXIS_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // Fields from bit 0 up: a_center, a_axis_x, a_axis_y, a_axis_z, a_extents,
  // b_center, b_axis_x, b_axis_y, b_axis_z, b_extents.
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // Fields from bit 0 up: depth (27 bits, signed), then zero fill.
  output logic [OUT_DATA_W-1:0] out_tdata,
  // Fields from bit 0 up: boxes_overlap.
  output logic                  out_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [EPS_W-1:0]      cfg_data
);

  localparam int P    = POS_BITS;
  localparam int A    = AXIS_BITS;
  localparam int F    = A - 2;
  localparam int RW   = A + 4;
  localparam int PW   = P + A + 3;
  localparam int OV_W = P + 2 * A + 9;
  localparam logic signed [OV_W-1:0] SAT_HI = OV_W'(DEPTH_MAX);
  localparam logic signed [OV_W-1:0] SAT_LO = OV_W'(DEPTH_MIN);

  // Config register, always ready; user writes must happen only while idle, unchecked.
  logic [EPS_W-1:0] eps_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else if (cfg_valid) begin
      eps_r <= cfg_data;
    end
  end

  // The whole chain advances unless the skid stage holds a result.
  logic skid_v_r;
  logic en;
  assign en        = !skid_v_r;
  assign in_tready = en;

  // Signals between the front end and the cells, one boundary per cell.
  obbpd_ctl_t             ctl_c  [N_AXES+1];
  logic signed [OV_W-1:0] best_c [N_AXES+1];
  logic [P-1:0]           ea_c   [N_AXES+1][3];
  logic [P-1:0]           eb_c   [N_AXES+1][3];
  logic [RW-1:0]          ar_c   [N_AXES+1][3][3];
  logic signed [RW-1:0]   r_c    [N_AXES+1][3][3];
  logic signed [PW-1:0]   p_c    [N_AXES+1][3];
  logic signed [PW-1:0]   q_c    [N_AXES+1][3];
  logic                   prep_vld;

  obbpd_prep #(.P(P), .A(A)) u_prep (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (in_tvalid),
    .data_i (in_tdata),
    .eps_i  (eps_r),
    .vld_o  (prep_vld),
    .ea_o   (ea_c[0]),
    .eb_o   (eb_c[0]),
    .ar_o   (ar_c[0]),
    .r_o    (r_c[0]),
    .p_o    (p_c[0]),
    .q_o    (q_c[0])
  );

  // The first cell sees a fresh result: nothing separated, no minimum yet.
  always_comb begin
    ctl_c[0].vld  = prep_vld;
    ctl_c[0].sep  = 1'b0;
    ctl_c[0].have = 1'b0;
    best_c[0]     = '0;
  end

  // Cells test the axes in order: A's axes, B's axes, then the nine cross products.
  generate
    for (genvar k = 0; k < N_AXES; k++) begin : g_cell
      obbpd_cell #(.P(P), .A(A), .K(k)) u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .ctl_i  (ctl_c[k]),
        .best_i (best_c[k]),
        .ea_i   (ea_c[k]),
        .eb_i   (eb_c[k]),
        .ar_i   (ar_c[k]),
        .r_i    (r_c[k]),
        .p_i    (p_c[k]),
        .q_i    (q_c[k]),
        .ctl_o  (ctl_c[k+1]),
        .best_o (best_c[k+1]),
        .ea_o   (ea_c[k+1]),
        .eb_o   (eb_c[k+1]),
        .ar_o   (ar_c[k+1]),
        .r_o    (r_c[k+1]),
        .p_o    (p_c[k+1]),
        .q_o    (q_c[k+1])
      );
    end
  endgenerate

  // Depth is the overlap floored to 8 fraction bits, then saturated.
  logic signed [OV_W-1:0] dep_w;
  logic [DEPTH_W-1:0]     res_depth;
  logic                   res_overlap;
  logic                   res_v;

  always_comb begin
    dep_w = best_c[N_AXES] >>> (2 * F);
    if (dep_w > SAT_HI) begin
      res_depth = DEPTH_W'(SAT_HI);
    end else if (dep_w < SAT_LO) begin
      res_depth = DEPTH_W'(SAT_LO);
    end else begin
      res_depth = DEPTH_W'(dep_w);
    end
    res_overlap = !ctl_c[N_AXES].sep;
    res_v       = ctl_c[N_AXES].vld;
  end

  // Output register with one skid entry behind it. A result leaving the chain goes
  // to the output register when that is free or its transfer completes now, and
  // to the skid entry otherwise; the skid entry then stops the chain.
  logic               out_v_r;
  logic [DEPTH_W-1:0] out_depth_r, skid_depth_r;
  logic               out_ovl_r, skid_ovl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_tready) begin
        skid_v_r <= 1'b0;
      end
    end else if (!out_v_r || out_tready) begin
      out_v_r <= res_v;
    end else if (res_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_tready) begin
        out_depth_r <= skid_depth_r;
        out_ovl_r   <= skid_ovl_r;
      end
    end else if (!out_v_r || out_tready) begin
      out_depth_r <= res_depth;
      out_ovl_r   <= res_overlap;
    end else begin
      skid_depth_r <= res_depth;
      skid_ovl_r   <= res_overlap;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_DATA_W'(out_depth_r);
  assign out_tuser  = out_ovl_r;

endmodule
